// ----- rtl/core/owlr_pkg.sv -----
// Shared types and constants of the overwrite-oldest log ring.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package owlr_pkg;

	localparam int OWLR_STORE_DEPTH = 1024;	// default byte slots of the log memory
	localparam int OWLR_CAP_RESET   = 1024;	// capacity after reset (clipped to depth)

	localparam int FUNC_W   = 2;
	localparam int LEN_W    = 11;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;
	localparam int CAP_W    = 11;

	// command codes
	localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// response status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_MSG    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [LEN_W-1:0]  message_length;
		logic [BYTE_W-1:0] write_byte;
	} cmd_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   read_byte;
		logic                end_of_log;
		logic [COUNT_W-1:0]  stored_bytes;
	} rsp_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/overwrite_oldest_log_ring_unit.sv -----
// Overwrite-oldest byte ring for a diagnostic log, with snapshot reader.
// Depends on owlr_pkg (request types, command and status codes).
`default_nettype none

// Byte log ring. A begin request announces a message length; lengths at or
// above the capacity are refused and the following write requests of that
// message come back with an error status. Each accepted byte lands in the
// next write slot; once capacity bytes are held, every new byte evicts the
// oldest one. A read request opens a session on first use that snapshots
// the oldest position and the byte count, then returns one byte per read
// request and flags the last one with end_of_log. Writing the capacity
// register (clamped to 2..STORE_DEPTH) empties the log and closes any open
// message or read session; write it only while no request is in flight.
// Throughput is one request per clock while the response is not stalled.
// Each accepted request passes the registered read port of the log memory
// and then the response register before its response appears. Pointers
// and counts live in flops and are updated at acceptance, so the next
// request always sees them current; the memory is written at acceptance
// too, and because only one request enters per cycle a read always comes
// in a later cycle than an earlier write, so no bypass is needed. The
// memory needs no clearing pass after reset: only written slots are read.
module overwrite_oldest_log_ring_unit #(
	parameter int STORE_DEPTH = owlr_pkg::OWLR_STORE_DEPTH
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// command channel
	input  wire                           cmd_valid,
	output logic                          cmd_stall,
	input  wire owlr_pkg::cmd_req_t       cmd,
	// response channel
	output logic                          rsp_valid,
	input  wire                           rsp_stall,
	output owlr_pkg::rsp_req_t            rsp,
	// capacity register
	input  wire                           cfg_we,
	input  wire [owlr_pkg::CAP_W-1:0]     cfg_wdata
);
	import owlr_pkg::*;

	localparam int PTR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);	// holds STORE_DEPTH itself
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int CAP_RST = (OWLR_CAP_RESET > STORE_DEPTH) ? STORE_DEPTH : OWLR_CAP_RESET;

	// next position, wrapping at the capacity
	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] pos,
	                                             input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = CNT_W'(pos) + CNT_W'(1);
		return (n >= cap) ? '0 : n[PTR_W-1:0];
	endfunction

	// ---------------- architectural state ----------------
	logic [CNT_W-1:0] capacity_q;
	logic [PTR_W-1:0] oldest_pos_q, next_wr_pos_q, read_pos_q;
	logic [CNT_W-1:0] stored_cnt_q, read_left_q;
	logic [LEN_W-1:0] msg_left_q;
	logic             read_active_q;

	logic [PTR_W-1:0] oldest_pos_n, next_wr_pos_n, read_pos_n;
	logic [CNT_W-1:0] stored_cnt_n, read_left_n;
	logic [LEN_W-1:0] msg_left_n;
	logic             read_active_n;

	// ---------------- log memory ----------------
	logic [BYTE_W-1:0] log_mem [STORE_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;
	logic              mem_we, mem_re;
	logic [PTR_W-1:0]  mem_raddr;

	// ---------------- pipeline ----------------
	logic     s1_valid_s1, s1_use_rd_s1;
	rsp_req_t s1_rsp_s1;
	logic     rsp_valid_q;
	rsp_req_t rsp_q;
	rsp_req_t rsp_d;

	logic     cmd_fire, s1_adv;
	rsp_req_t res;
	logic     use_rd;

	// clamped capacity value for a register write
	logic [CMP_W-1:0] cfg_ext;
	logic [CNT_W-1:0] cfg_cap;

	always_comb begin
		cfg_ext = CMP_W'(cfg_wdata);
		if (cfg_ext < CMP_W'(2)) begin
			cfg_cap = CNT_W'(2);
		end else if (cfg_ext > CMP_W'(STORE_DEPTH)) begin
			cfg_cap = CNT_W'(STORE_DEPTH);
		end else begin
			cfg_cap = cfg_ext[CNT_W-1:0];
		end
	end

	// stage 1 moves on when the response register is free or being emptied
	assign s1_adv    = s1_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = s1_valid_s1 && !s1_adv;
	assign cmd_fire  = cmd_valid && !cmd_stall;

	// request decode and state update
	always_comb begin
		oldest_pos_n  = oldest_pos_q;
		next_wr_pos_n = next_wr_pos_q;
		read_pos_n    = read_pos_q;
		stored_cnt_n  = stored_cnt_q;
		read_left_n   = read_left_q;
		msg_left_n    = msg_left_q;
		read_active_n = read_active_q;
		res           = '0;
		use_rd        = 1'b0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_raddr     = read_pos_q;

		unique case (cmd.func)
			FUNC_BEGIN: begin
				if (CMP_W'(cmd.message_length) >= CMP_W'(capacity_q)) begin
					res.status = ST_TOO_LARGE;
					msg_left_n = '0;
				end else begin
					msg_left_n = cmd.message_length;
				end
			end
			FUNC_WRITE: begin
				if (msg_left_q == '0) begin
					res.status = ST_NO_MSG;
				end else begin
					// full: evict oldest, count stays the same
					if (stored_cnt_q >= capacity_q) begin
						oldest_pos_n = advance(oldest_pos_q, capacity_q);
					end else begin
						stored_cnt_n = stored_cnt_q + CNT_W'(1);
					end
					mem_we        = 1'b1;
					next_wr_pos_n = advance(next_wr_pos_q, capacity_q);
					msg_left_n    = msg_left_q - LEN_W'(1);
				end
			end
			FUNC_READ: begin
				if (!read_active_q && stored_cnt_q == '0) begin
					res.status     = ST_EMPTY;
					res.end_of_log = 1'b1;
				end else begin
					// open a session with a snapshot if none is running
					if (!read_active_q) begin
						mem_raddr   = oldest_pos_q;
						read_left_n = stored_cnt_q;
					end
					mem_re        = 1'b1;
					use_rd        = 1'b1;
					read_pos_n    = advance(mem_raddr, capacity_q);
					if (read_left_n != '0) begin
						read_left_n = read_left_n - CNT_W'(1);
					end
					read_active_n = (read_left_n != '0);
					res.end_of_log = (read_left_n == '0);
				end
			end
			default: begin
			end
		endcase

		res.stored_bytes = COUNT_W'(stored_cnt_n);
	end

	// state registers; a capacity write empties the log
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q    <= CNT_W'(CAP_RST);
			oldest_pos_q  <= '0;
			next_wr_pos_q <= '0;
			read_pos_q    <= '0;
			stored_cnt_q  <= '0;
			read_left_q   <= '0;
			msg_left_q    <= '0;
			read_active_q <= 1'b0;
		end else if (cfg_we) begin
			capacity_q    <= cfg_cap;
			oldest_pos_q  <= '0;
			next_wr_pos_q <= '0;
			read_pos_q    <= '0;
			stored_cnt_q  <= '0;
			read_left_q   <= '0;
			msg_left_q    <= '0;
			read_active_q <= 1'b0;
		end else if (cmd_fire) begin
			oldest_pos_q  <= oldest_pos_n;
			next_wr_pos_q <= next_wr_pos_n;
			read_pos_q    <= read_pos_n;
			stored_cnt_q  <= stored_cnt_n;
			read_left_q   <= read_left_n;
			msg_left_q    <= msg_left_n;
			read_active_q <= read_active_n;
		end
	end

	// log memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd_fire && mem_we) begin
			log_mem[next_wr_pos_q] <= cmd.write_byte;
		end
		if (cmd_fire && mem_re) begin
			rd_data_q <= log_mem[mem_raddr];
		end
	end

	// stage 1: waits for memory data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (cmd_fire) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			s1_rsp_s1    <= res;
			s1_use_rd_s1 <= use_rd;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// merge the memory data into the stage 1 response
	always_comb begin
		rsp_d           = s1_rsp_s1;
		rsp_d.read_byte = s1_use_rd_s1 ? rd_data_q : '0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/core/owlr_check.sv -----
// Port-level checker for the overwrite-oldest log ring, bound to the top.
// Depends on owlr_pkg for request types and status codes.
`default_nettype none

module owlr_check (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  cmd_valid,
	input wire                  cmd_stall,
	input wire                  rsp_valid,
	input wire                  rsp_stall,
	input wire owlr_pkg::rsp_req_t rsp
);
	import owlr_pkg::*;

	// requests accepted but not yet answered
	logic [2:0] pending_q;
	logic       cmd_fire, rsp_fire;

	assign cmd_fire = cmd_valid && !cmd_stall;
	assign rsp_fire = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (cmd_fire && !rsp_fire) begin
			pending_q <= pending_q + 3'd1;
		end else if (!cmd_fire && rsp_fire) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 3'd0)
		else $error("response without an outstanding request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more than two requests in flight");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_TOO_LARGE || rsp.status == ST_NO_MSG)
		|-> rsp.read_byte == '0 && !rsp.end_of_log)
		else $error("error response carries read data");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY
		|-> rsp.end_of_log && rsp.stored_bytes == '0 && rsp.read_byte == '0)
		else $error("empty-log response inconsistent");

endmodule

bind overwrite_oldest_log_ring_unit owlr_check u_owlr_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
